[src/beoc_pkg.sv]
`timescale 1ns / 1ps

package beoc_pkg;

	localparam int ROW_W        = 32;
	localparam int ERO_W        = 30;
	localparam int SIZE_W       = 6;
	localparam int SE_W         = 9;
	localparam int DATA_W       = 32;
	localparam int ADDR_W       = 3;
	localparam int MAX_SIZE_DEF = 32;
	localparam int MIN_SIZE     = 3;

	localparam logic [0:0] REG_IMAGE_SIZE  = 1'b0;
	localparam logic [0:0] REG_STRUCT_ELEM = 1'b1;

	localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(MIN_SIZE);
	localparam logic [SE_W-1:0]   SE_RST   = '0;

	typedef struct packed {
		logic              wr;
		logic [SIZE_W-1:0] wr_addr;
		logic              rd;
		logic [SIZE_W-1:0] rd_addr;
		logic              clr;
		logic              shift;
		logic              keep;
		logic              cmp;
		logic              emit_mid;
		logic              emit_last;
	} beoc_cmd_t;

	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] sz,
			input logic [SIZE_W-1:0] lim);
		logic [SIZE_W-1:0] n;
		n = (sz < SIZE_W'(MIN_SIZE)) ? SIZE_W'(MIN_SIZE) : sz;
		if (n > lim) begin
			n = lim;
		end
		return n;
	endfunction

	function automatic logic [ROW_W-1:0] erode_row(input logic [ROW_W-1:0] r0,
			input logic [ROW_W-1:0] r1, input logic [ROW_W-1:0] r2,
			input logic [SE_W-1:0] se);
		logic [ROW_W-1:0] fit;
		fit = '1;
		fit &= {ROW_W{~se[0]}} | (r0 << 1);
		fit &= {ROW_W{~se[1]}} | r0;
		fit &= {ROW_W{~se[2]}} | (r0 >> 1);
		fit &= {ROW_W{~se[3]}} | (r1 << 1);
		fit &= {ROW_W{~se[4]}} | r1;
		fit &= {ROW_W{~se[5]}} | (r1 >> 1);
		fit &= {ROW_W{~se[6]}} | (r2 << 1);
		fit &= {ROW_W{~se[7]}} | r2;
		fit &= {ROW_W{~se[8]}} | (r2 >> 1);
		return fit;
	endfunction

	// up is eroded row t-1, mid row t, dn row t+1
	function automatic logic [ROW_W-1:0] dilate_row(input logic [ROW_W-1:0] up,
			input logic [ROW_W-1:0] mid, input logic [ROW_W-1:0] dn,
			input logic [SE_W-1:0] se);
		logic [ROW_W-1:0] acc;
		acc = '0;
		acc |= {ROW_W{se[0]}} & (dn >> 1);
		acc |= {ROW_W{se[1]}} & dn;
		acc |= {ROW_W{se[2]}} & (dn << 1);
		acc |= {ROW_W{se[3]}} & (mid >> 1);
		acc |= {ROW_W{se[4]}} & mid;
		acc |= {ROW_W{se[5]}} & (mid << 1);
		acc |= {ROW_W{se[6]}} & (up >> 1);
		acc |= {ROW_W{se[7]}} & up;
		acc |= {ROW_W{se[8]}} & (up << 1);
		return acc;
	endfunction

endpackage

[src/beoc_ctrl.sv]
`timescale 1ns / 1ps

module beoc_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [beoc_pkg::SIZE_W-1:0]    n,
	output logic                           busy,
	output beoc_pkg::beoc_cmd_t            cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic                        state_q;
	logic [beoc_pkg::SIZE_W-1:0] rows_q;
	logic [beoc_pkg::SIZE_W-1:0] cnt_q;
	logic [beoc_pkg::SIZE_W-1:0] rows_next;

	assign rows_next = rows_q + beoc_pkg::SIZE_W'(1);
	assign busy      = (state_q == ST_RUN);

	always_comb begin
		cmd           = '0;
		cmd.wr_addr   = rows_q;
		cmd.rd_addr   = cnt_q;
		case (state_q)
			ST_IDLE: begin
				cmd.wr  = start && (rows_q < n);
				cmd.clr = start && (rows_next >= n);
			end
			ST_RUN: begin
				cmd.rd        = (cnt_q < n);
				cmd.shift     = 1'b1;
				cmd.keep      = (cnt_q >= beoc_pkg::SIZE_W'(3)) && (cnt_q <= n);
				cmd.cmp       = (cnt_q >= beoc_pkg::SIZE_W'(4));
				cmd.emit_mid  = (cnt_q >= beoc_pkg::SIZE_W'(3)) && (cnt_q < n);
				cmd.emit_last = (cnt_q == n + beoc_pkg::SIZE_W'(3));
			end
			default: begin
				cmd.wr = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rows_q  <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (rows_next >= n) begin
							rows_q  <= '0;
							cnt_q   <= '0;
							state_q <= ST_RUN;
						end else begin
							rows_q <= rows_next;
						end
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + beoc_pkg::SIZE_W'(1);
					if (cmd.emit_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[src/beoc_dp.sv]
`timescale 1ns / 1ps

module beoc_dp #(
	parameter int MAX_SIZE = beoc_pkg::MAX_SIZE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  beoc_pkg::beoc_cmd_t           cmd,
	input  logic [beoc_pkg::SIZE_W-1:0]   n,
	input  logic [beoc_pkg::SE_W-1:0]     se,
	input  logic [beoc_pkg::ROW_W-1:0]    pixel_row,
	output logic                          strobe,
	output logic [beoc_pkg::ERO_W-1:0]    eroded_row,
	output logic                          opening_match,
	output logic                          last_row
);

	localparam int DEPTH = (MAX_SIZE < beoc_pkg::ROW_W) ? MAX_SIZE : beoc_pkg::ROW_W;
	localparam int AW    = $clog2(DEPTH);

	logic [beoc_pkg::ROW_W-1:0] mem [DEPTH];
	logic [beoc_pkg::ROW_W-1:0] rd_q;
	logic [beoc_pkg::ROW_W-1:0] iw_old_q, iw_mid_q, iw_new_q;
	logic [beoc_pkg::ROW_W-1:0] e_old_q, e_mid_q, e_new_q;
	logic                       match_q;
	logic                       strobe_q, match_out_q, last_q;
	logic [beoc_pkg::ERO_W-1:0] eroded_q;

	logic [beoc_pkg::ROW_W-1:0] mask, int_mask, e_comb, open_row;
	logic                       cmp_ok;

	assign mask     = ~({beoc_pkg::ROW_W{1'b1}} << n);
	assign int_mask = (mask >> 1) & ~beoc_pkg::ROW_W'(1);
	assign e_comb   = cmd.keep
		? (beoc_pkg::erode_row(iw_mid_q, iw_new_q, rd_q, se) & int_mask) : '0;
	assign open_row = beoc_pkg::dilate_row(e_old_q, e_mid_q, e_new_q, se);
	assign cmp_ok   = ((open_row & mask) == iw_old_q);

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[cmd.wr_addr[AW-1:0]] <= pixel_row & mask;
		end
		if (cmd.rd) begin
			rd_q <= mem[cmd.rd_addr[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			iw_old_q <= iw_mid_q;
			iw_mid_q <= iw_new_q;
			iw_new_q <= rd_q;
			e_old_q  <= e_mid_q;
			e_mid_q  <= e_new_q;
			e_new_q  <= e_comb;
		end
		if (cmd.emit_mid) begin
			eroded_q <= e_comb[beoc_pkg::ERO_W:1];
		end else if (cmd.emit_last) begin
			eroded_q <= e_old_q[beoc_pkg::ERO_W:1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q     <= 1'b1;
			strobe_q    <= 1'b0;
			match_out_q <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			if (cmd.clr) begin
				match_q <= 1'b1;
			end else if (cmd.cmp) begin
				match_q <= match_q & cmp_ok;
			end
			strobe_q    <= cmd.emit_mid | cmd.emit_last;
			last_q      <= cmd.emit_last;
			match_out_q <= cmd.emit_last & match_q & cmp_ok;
		end
	end

	assign strobe        = strobe_q;
	assign eroded_row    = eroded_q;
	assign opening_match = match_out_q;
	assign last_row      = last_q;

endmodule

[src/binary_erosion_opening_check_core.sv]
`timescale 1ns / 1ps

// Binary 3x3 opening check. Write image_size (byte address 0) and struct_elem
// (byte address 4) over the APB port while the block is idle. Pulse start with
// one image row on pixel_row per cycle. The n-th row makes busy rise, and
// while busy one pass walks the image memory a row per cycle through a
// three-row window, eroding and re-dilating on the fly. The n-2 eroded rows
// come out on strobe, one cycle each, in row order; the last one, with
// last_row and opening_match, shows in the cycle busy falls.
// The receiver cannot hold results off: sample every strobe.
module binary_erosion_opening_check_core #(
	parameter int MAX_SIZE = beoc_pkg::MAX_SIZE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [beoc_pkg::ADDR_W-1:0]   paddr,
	input  logic [beoc_pkg::DATA_W-1:0]   pwdata,
	output logic [beoc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          start,
	output logic                          busy,
	input  logic [beoc_pkg::ROW_W-1:0]    pixel_row,
	output logic                          strobe,
	output logic [beoc_pkg::ERO_W-1:0]    eroded_row,
	output logic                          opening_match,
	output logic                          last_row
);

	localparam int LIM = (MAX_SIZE < beoc_pkg::ROW_W) ? MAX_SIZE : beoc_pkg::ROW_W;

	logic [beoc_pkg::SIZE_W-1:0] size_q;
	logic [beoc_pkg::SE_W-1:0]   se_q;
	logic [beoc_pkg::SIZE_W-1:0] n;
	logic                        wr_en;
	beoc_pkg::beoc_cmd_t         cmd;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign n      = beoc_pkg::eff_size(size_q, beoc_pkg::SIZE_W'(LIM));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= beoc_pkg::SIZE_RST;
			se_q   <= beoc_pkg::SE_RST;
		end else if (wr_en) begin
			case (paddr[2:2])
				beoc_pkg::REG_IMAGE_SIZE:  size_q <= pwdata[beoc_pkg::SIZE_W-1:0];
				beoc_pkg::REG_STRUCT_ELEM: se_q   <= pwdata[beoc_pkg::SE_W-1:0];
				default: size_q <= size_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2:2])
			beoc_pkg::REG_IMAGE_SIZE:  prdata = beoc_pkg::DATA_W'(size_q);
			beoc_pkg::REG_STRUCT_ELEM: prdata = beoc_pkg::DATA_W'(se_q);
			default:                   prdata = '0;
		endcase
	end

	beoc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.n      (n),
		.busy   (busy),
		.cmd    (cmd)
	);

	beoc_dp #(
		.MAX_SIZE (MAX_SIZE)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.n             (n),
		.se            (se_q),
		.pixel_row     (pixel_row),
		.strobe        (strobe),
		.eroded_row    (eroded_row),
		.opening_match (opening_match),
		.last_row      (last_row)
	);

endmodule

[src/beoc_check.sv]
`timescale 1ns / 1ps

module beoc_check (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          busy,
	input logic                          strobe,
	input logic                          opening_match,
	input logic                          last_row
);

	a_match_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(opening_match || last_row) |-> (strobe && last_row))
		else $error("match or last flag outside the final item");

	a_strobe_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (busy || $past(busy)))
		else $error("item strobed while idle");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (strobe && last_row))
		else $error("run ended without final item");

	a_last_not_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last_row) |-> !busy)
		else $error("final item while still busy");

endmodule

bind binary_erosion_opening_check_core beoc_check u_beoc_check (.*);
